// ===== src/double_int_to_shortest_digits_unit_assert.svh =====
// Assertion macros for the checker file of this block.
`ifndef DOUBLE_INT_TO_SHORTEST_DIGITS_UNIT_ASSERT_SVH
`define DOUBLE_INT_TO_SHORTEST_DIGITS_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define DSD_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define DSD_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/dsd_pkg.sv =====
`default_nettype none

package dsd_pkg;

  // Datapath widths.
  localparam int unsigned VAL_W   = 128;
  localparam int unsigned NDIGITS = 39;
  localparam int unsigned BCD_W   = 4 * NDIGITS;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned EXP_W   = 6;
  localparam int unsigned POS_W   = 6;
  localparam int unsigned CNT_W   = 7;

  // Accepted exponent and fraction range of the binary64 input.
  localparam logic [10:0] BEXP_MIN   = 11'd1076;
  localparam logic [10:0] BEXP_MAX   = 11'd1150;
  localparam logic [10:0] BEXP_BIAS  = 11'd1075;
  localparam logic [51:0] FRAC_LIMIT = 52'hF_FFFF_FFFF_FFF4;

  // Decimal positions used by the digit scan.
  localparam logic [POS_W-1:0] TOP_POS = 6'd38;
  localparam logic [POS_W-1:0] CMP_TOP = 6'd37;

  // Controller states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REJECT,
    ST_DABBLE,
    ST_SCAN,
    ST_PREP,
    ST_EMIT
  } state_e;

  // Commands to one binary-to-decimal lane.
  typedef struct packed {
    logic load;
    logic step;
    logic dshift;
  } lane_ctl_t;

endpackage

`default_nettype wire

// ===== src/dsd_bounds.sv =====
`default_nettype none

module dsd_bounds (
  input  wire logic [63:0]                value_bits_i,
  output logic                            ok_o,
  output logic [dsd_pkg::VAL_W-1:0]       centre_o,
  output logic [dsd_pkg::VAL_W-1:0]       lo_o,
  output logic [dsd_pkg::VAL_W-1:0]       hi_o
);

  logic                       sgn;
  logic [10:0]                bexp;
  logic [51:0]                frac;
  logic [52:0]                mant;
  logic [10:0]                sh_full;
  logic [6:0]                 sh;
  logic [dsd_pkg::VAL_W-1:0]  gap_lo;
  logic [dsd_pkg::VAL_W-1:0]  gap_hi;
  logic [dsd_pkg::VAL_W-1:0]  one;

  assign sgn  = value_bits_i[63];
  assign bexp = value_bits_i[62:52];
  assign frac = value_bits_i[51:0];
  assign mant = {1'b1, frac};
  assign one  = {{(dsd_pkg::VAL_W-1){1'b0}}, 1'b1};

  // Range check: positive, at least 2^53 (hence integral), below the upper limit.
  assign ok_o = !sgn && (bexp >= dsd_pkg::BEXP_MIN) &&
                ((bexp < dsd_pkg::BEXP_MAX) ||
                 ((bexp == dsd_pkg::BEXP_MAX) && (frac < dsd_pkg::FRAC_LIMIT)));

  // Exact integer value and the two half-gaps.
  assign sh_full  = bexp - dsd_pkg::BEXP_BIAS;
  assign sh       = sh_full[6:0];
  assign centre_o = {{(dsd_pkg::VAL_W-53){1'b0}}, mant} << sh;
  assign gap_lo   = one << (sh - 7'd1);

  always_comb begin
    if (frac != '0) begin
      gap_hi = gap_lo;
    end else if (sh >= 7'd2) begin
      gap_hi = one << (sh - 7'd2);
    end else begin
      gap_hi = '0;
    end
  end

  // Tighten one bound depending on mantissa parity.
  assign lo_o = centre_o - gap_lo - {{(dsd_pkg::VAL_W-1){1'b0}}, ~mant[0]};
  assign hi_o = centre_o + gap_hi - {{(dsd_pkg::VAL_W-1){1'b0}}, mant[0]};

endmodule

`default_nettype wire

// ===== src/dsd_dabble.sv =====
`default_nettype none

module dsd_dabble (
  input  wire logic                        clk_i,
  input  wire dsd_pkg::lane_ctl_t          ctl_i,
  input  wire logic [dsd_pkg::VAL_W-1:0]   value_i,
  output logic [dsd_pkg::DIGIT_W-1:0]      top_o,
  output logic [dsd_pkg::DIGIT_W-1:0]      next_o
);

  logic [dsd_pkg::VAL_W-1:0] bin_q;
  logic [dsd_pkg::BCD_W-1:0] bcd_q;
  logic [dsd_pkg::BCD_W-1:0] bcd_adj;

  // Add three to every digit of five or more before the next shift.
  always_comb begin
    for (int i = 0; i < dsd_pkg::NDIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  // One binary bit enters per step; afterwards digits leave from the top.
  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      bin_q <= value_i;
      bcd_q <= '0;
    end else if (ctl_i.step) begin
      bin_q <= {bin_q[dsd_pkg::VAL_W-2:0], 1'b0};
      bcd_q <= {bcd_adj[dsd_pkg::BCD_W-2:0], bin_q[dsd_pkg::VAL_W-1]};
    end else if (ctl_i.dshift) begin
      bcd_q <= {bcd_q[dsd_pkg::BCD_W-5:0], 4'd0};
    end
  end

  assign top_o  = bcd_q[dsd_pkg::BCD_W-1 -: 4];
  assign next_o = bcd_q[dsd_pkg::BCD_W-5 -: 4];

endmodule

`default_nettype wire

// ===== src/double_int_to_shortest_digits_unit.sv =====
// Converts the bit pattern of a positive integral double in [2^53, 3.4e38) into
// its shortest decimal digits, one beat per digit, most significant first; the
// last beat carries tlast and the decimal exponent. An input outside that range
// gives one beat with tuser set. One value is handled at a time: the input is
// ready only while the unit is idle. A value passes through a load step, a
// bit-serial binary-to-decimal conversion of the value and both bounds over the
// 128-bit word, a digit scan, a setup step and the emission of one digit per
// cycle while the output is not stalled; a rejected input goes from the load
// step to the reject state, which emits its single beat.
`default_nettype none

module double_int_to_shortest_digits_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [63:0] s_axis_tdata_i,   // [63:0] value_bits
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // [3:0] digit, [9:4] dec_exponent, zero pad
  output logic             m_axis_tlast_o,   // last
  output logic             m_axis_tuser_o    // [0] out_of_range
);

  localparam int unsigned PW = dsd_pkg::POS_W;

  dsd_pkg::state_e state_q, state_d;

  logic                        in_ok;
  logic [dsd_pkg::VAL_W-1:0]   in_centre, in_lo, in_hi;
  dsd_pkg::lane_ctl_t          ctl_v, ctl_b;
  logic [dsd_pkg::DIGIT_W-1:0] v_top, v_next, lo_top, lo_next, hi_top, hi_next;

  logic [dsd_pkg::CNT_W-1:0] dab_cnt_q, dab_cnt_d;
  logic [PW-1:0]             idx_q, idx_d;
  logic [PW-1:0]             pos_q, pos_d;
  logic                      pos_found_q, pos_found_d;
  logic [PW-1:0]             msd_q, msd_d;
  logic                      msd_found_q, msd_found_d;
  logic                      round_q, round_d;
  logic                      zero_q, zero_d;
  logic [PW-1:0]             endp_q, endp_d;
  logic [dsd_pkg::EXP_W-1:0] ex_q, ex_d;
  logic [PW-1:0]             cur_q, cur_d;

  logic                        out_valid_q, out_valid_d;
  logic [dsd_pkg::DIGIT_W-1:0] out_digit_q, out_digit_d;
  logic                        out_last_q, out_last_d;
  logic [dsd_pkg::EXP_W-1:0]   out_exp_q, out_exp_d;
  logic                        out_oor_q, out_oor_d;

  logic          slot_free;
  logic          emit_last;
  logic [PW-1:0] prep_e;

  // Range check and bounds of the incoming value.
  dsd_bounds u_bounds (
    .value_bits_i (s_axis_tdata_i),
    .ok_o         (in_ok),
    .centre_o     (in_centre),
    .lo_o         (in_lo),
    .hi_o         (in_hi)
  );

  // Three serial decimal converters: value, low bound, high bound.
  dsd_dabble u_lane_v (
    .clk_i   (clk_i),
    .ctl_i   (ctl_v),
    .value_i (in_centre),
    .top_o   (v_top),
    .next_o  (v_next)
  );

  dsd_dabble u_lane_lo (
    .clk_i   (clk_i),
    .ctl_i   (ctl_b),
    .value_i (in_lo),
    .top_o   (lo_top),
    .next_o  (lo_next)
  );

  dsd_dabble u_lane_hi (
    .clk_i   (clk_i),
    .ctl_i   (ctl_b),
    .value_i (in_hi),
    .top_o   (hi_top),
    .next_o  (hi_next)
  );

  // The lookahead digits of the bound lanes are not needed by the scan.
  logic unused_next;
  assign unused_next = ^{lo_next, hi_next};

  // Lowest kept decimal position before rounding.
  assign prep_e    = (pos_q == '0) ? '0 : pos_q - 6'd1;
  assign slot_free = !out_valid_q || m_axis_tready_i;
  assign emit_last = (cur_q == endp_q);

  // State register and control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dsd_pkg::ST_IDLE;
      dab_cnt_q   <= '0;
      idx_q       <= '0;
      pos_q       <= '0;
      pos_found_q <= 1'b0;
      msd_q       <= '0;
      msd_found_q <= 1'b0;
      round_q     <= 1'b0;
      zero_q      <= 1'b0;
      endp_q      <= '0;
      ex_q        <= '0;
      cur_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      dab_cnt_q   <= dab_cnt_d;
      idx_q       <= idx_d;
      pos_q       <= pos_d;
      pos_found_q <= pos_found_d;
      msd_q       <= msd_d;
      msd_found_q <= msd_found_d;
      round_q     <= round_d;
      zero_q      <= zero_d;
      endp_q      <= endp_d;
      ex_q        <= ex_d;
      cur_q       <= cur_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Output beat payload.
  always_ff @(posedge clk_i) begin
    out_digit_q <= out_digit_d;
    out_last_q  <= out_last_d;
    out_exp_q   <= out_exp_d;
    out_oor_q   <= out_oor_d;
  end

  // Next state, lane commands and output beats.
  always_comb begin
    state_d     = state_q;
    dab_cnt_d   = dab_cnt_q;
    idx_d       = idx_q;
    pos_d       = pos_q;
    pos_found_d = pos_found_q;
    msd_d       = msd_q;
    msd_found_d = msd_found_q;
    round_d     = round_q;
    zero_d      = zero_q;
    endp_d      = endp_q;
    ex_d        = ex_q;
    cur_d       = cur_q;
    out_valid_d = out_valid_q && !m_axis_tready_i;
    out_digit_d = out_digit_q;
    out_last_d  = out_last_q;
    out_exp_d   = out_exp_q;
    out_oor_d   = out_oor_q;
    ctl_v       = '0;
    ctl_b       = '0;

    case (state_q)
      dsd_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) begin
          ctl_v.load  = 1'b1;
          ctl_b.load  = 1'b1;
          dab_cnt_d   = '0;
          idx_d       = dsd_pkg::TOP_POS;
          pos_d       = '0;
          pos_found_d = 1'b0;
          msd_d       = '0;
          msd_found_d = 1'b0;
          state_d     = in_ok ? dsd_pkg::ST_DABBLE : dsd_pkg::ST_REJECT;
        end
      end

      dsd_pkg::ST_REJECT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_digit_d = '0;
          out_last_d  = 1'b1;
          out_exp_d   = '0;
          out_oor_d   = 1'b1;
          state_d     = dsd_pkg::ST_IDLE;
        end
      end

      dsd_pkg::ST_DABBLE: begin
        ctl_v.step = 1'b1;
        ctl_b.step = 1'b1;
        dab_cnt_d  = dab_cnt_q + 7'd1;
        if (dab_cnt_q == 7'(dsd_pkg::VAL_W - 1)) begin
          state_d = dsd_pkg::ST_SCAN;
        end
      end

      dsd_pkg::ST_SCAN: begin
        // Bounds leave one digit a cycle; the value stops at its leading digit.
        ctl_b.dshift = 1'b1;
        if (!pos_found_q && (idx_q <= dsd_pkg::CMP_TOP) && (lo_top != hi_top)) begin
          pos_d       = idx_q;
          pos_found_d = 1'b1;
        end
        if (!msd_found_q) begin
          if (v_top != '0) begin
            msd_d       = idx_q;
            msd_found_d = 1'b1;
          end else begin
            ctl_v.dshift = 1'b1;
          end
        end
        if (idx_q == '0) begin
          state_d = dsd_pkg::ST_PREP;
        end else begin
          idx_d = idx_q - 6'd1;
        end
      end

      dsd_pkg::ST_PREP: begin
        zero_d  = (msd_q < prep_e);
        round_d = (pos_q != '0) && (msd_q >= pos_q);
        if ((pos_q != '0) && (msd_q >= pos_q)) begin
          endp_d = pos_q;
          ex_d   = msd_q + 6'd1;
        end else begin
          endp_d = prep_e;
          ex_d   = msd_q - prep_e + 6'd1 + pos_q;
        end
        if (msd_q < prep_e) begin
          ex_d = pos_q + 6'd1;
        end
        cur_d   = msd_q;
        state_d = dsd_pkg::ST_EMIT;
      end

      dsd_pkg::ST_EMIT: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          out_oor_d   = 1'b0;
          if (zero_q) begin
            out_digit_d = '0;
            out_last_d  = 1'b1;
            out_exp_d   = ex_q;
            state_d     = dsd_pkg::ST_IDLE;
          end else begin
            // The final kept digit takes the rounding of the digit below it.
            out_last_d = emit_last;
            if (emit_last && round_q && (v_next >= 4'd5)) begin
              out_digit_d = v_top + 4'd1;
            end else begin
              out_digit_d = v_top;
            end
            out_exp_d    = emit_last ? ex_q : '0;
            ctl_v.dshift = 1'b1;
            cur_d        = cur_q - 6'd1;
            if (emit_last) begin
              state_d = dsd_pkg::ST_IDLE;
            end
          end
        end
      end

      default: begin
        state_d = dsd_pkg::ST_IDLE;
      end
    endcase
  end

  assign s_axis_tready_o = (state_q == dsd_pkg::ST_IDLE);
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_exp_q, out_digit_q};
  assign m_axis_tlast_o  = out_last_q;
  assign m_axis_tuser_o  = out_oor_q;

endmodule

`default_nettype wire

// ===== src/dsd_checker.sv =====
`default_nettype none

`include "double_int_to_shortest_digits_unit_assert.svh"

module dsd_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        m_tvalid_i,
  input wire logic        m_tready_i,
  input wire logic [15:0] m_tdata_i,
  input wire logic        m_tlast_i,
  input wire logic        m_tuser_i
);

  // A rejected value is a run of exactly one beat.
  `DSD_ASSERT_IMP(a_oor_last, clk_i, rst_ni, m_tvalid_i && m_tuser_i, m_tlast_i, "flagged beat without tlast")

  // A rejected value carries digit zero and exponent zero.
  `DSD_ASSERT_IMP(a_oor_zero, clk_i, rst_ni, m_tvalid_i && m_tuser_i, m_tdata_i[9:0] == 10'd0, "flagged beat with nonzero data")

  // The exponent appears only on the final digit of a run.
  `DSD_ASSERT_IMP(a_exp_last, clk_i, rst_ni, m_tvalid_i && !m_tlast_i, m_tdata_i[9:4] == 6'd0, "exponent on an inner digit")

  // A stalled output beat holds.
  `DSD_ASSERT_NXT(a_hold, clk_i, rst_ni, m_tvalid_i && !m_tready_i, m_tvalid_i && $stable(m_tdata_i) && $stable(m_tlast_i) && $stable(m_tuser_i), "stalled beat changed")

endmodule

bind double_int_to_shortest_digits_unit dsd_checker u_dsd_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .m_tvalid_i (m_axis_tvalid_o),
  .m_tready_i (m_axis_tready_i),
  .m_tdata_i  (m_axis_tdata_o),
  .m_tlast_i  (m_axis_tlast_o),
  .m_tuser_i  (m_axis_tuser_o)
);

`default_nettype wire
